// ===== hdl/iiq_pkg.sv =====
package iiq_pkg;

  // Queue geometry.
  localparam int Depth      = 16;
  localparam int DataWidth  = 32;
  localparam int CountWidth = $clog2(Depth + 1);
  localparam int IdxWidth   = $clog2(Depth);
  localparam int PosWidth   = 4;
  localparam int CmdWidth   = 2;
  localparam int StatWidth  = 2;

  // Command codes.
  typedef enum logic [CmdWidth-1:0] {
    CmdEnqueue = 2'd0,
    CmdDequeue = 2'd1,
    CmdInsert  = 2'd2,
    CmdRemove  = 2'd3
  } cmd_e;

  // Status codes.
  typedef enum logic [StatWidth-1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2,
    StRange = 2'd3
  } status_e;

  // One registered request.
  typedef struct packed {
    cmd_e                 cmd;
    logic [PosWidth-1:0]  pos;
    logic [DataWidth-1:0] data;
  } req_t;

  // One result.
  typedef struct packed {
    status_e               status;
    logic [DataWidth-1:0]  head;
    logic [DataWidth-1:0]  tail;
    logic [CountWidth-1:0] count;
    logic                  empty;
  } rsp_t;

endpackage

// ===== hdl/iiq_core.sv =====
module iiq_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  iiq_pkg::req_t req_i,
  output iiq_pkg::rsp_t rsp_o
);
  import iiq_pkg::*;

  // Slot update kinds once a request has passed its checks.
  typedef enum logic [2:0] {
    OpKeep,
    OpEnq,
    OpDeq,
    OpIns,
    OpRem
  } op_e;

  logic [DataWidth-1:0]  slots_q [Depth];
  logic [DataWidth-1:0]  slots_d [Depth];
  logic [CountWidth-1:0] count_q, count_d;
  logic [CountWidth-1:0] pos_ext;
  logic [CountWidth-1:0] tail_sum;
  logic [IdxWidth-1:0]   tail_idx;
  logic                  full, empty, pos_ok;
  status_e               status;
  op_e                   op;

  assign pos_ext = CountWidth'(req_i.pos);
  assign full    = (count_q == CountWidth'(Depth));
  assign empty   = (count_q == '0);
  assign pos_ok  = (pos_ext < count_q);

  // Check the request and pick the slot update.
  always_comb begin
    status  = StOk;
    op      = OpKeep;
    count_d = count_q;
    if (req_valid_i) begin
      unique case (req_i.cmd)
        CmdEnqueue: begin
          if (full) begin
            status = StFull;
          end else begin
            op      = OpEnq;
            count_d = count_q + CountWidth'(1);
          end
        end
        CmdDequeue: begin
          if (empty) begin
            status = StEmpty;
          end else begin
            op      = OpDeq;
            count_d = count_q - CountWidth'(1);
          end
        end
        CmdInsert: begin
          if (full) begin
            status = StFull;
          end else if (!pos_ok) begin
            status = StRange;
          end else begin
            op      = OpIns;
            count_d = count_q + CountWidth'(1);
          end
        end
        default: begin
          if (empty) begin
            status = StEmpty;
          end else if (!pos_ok) begin
            status = StRange;
          end else begin
            op      = OpRem;
            count_d = count_q - CountWidth'(1);
          end
        end
      endcase
    end
  end

  // Each slot keeps its word, takes a neighbor, or takes the new word.
  always_comb begin
    logic [CountWidth-1:0] idx;
    idx = '0;
    for (int i = 0; i < Depth; i++) begin
      idx        = CountWidth'(i);
      slots_d[i] = slots_q[i];
      case (op)
        OpEnq: begin
          if (idx == count_q) slots_d[i] = req_i.data;
        end
        OpDeq: begin
          slots_d[i] = slots_q[(i < Depth - 1) ? i + 1 : i];
        end
        OpIns: begin
          if (idx > pos_ext) begin
            slots_d[i] = slots_q[(i > 0) ? i - 1 : 0];
          end else if (idx == pos_ext) begin
            slots_d[i] = req_i.data;
          end
        end
        OpRem: begin
          if (idx >= pos_ext) slots_d[i] = slots_q[(i < Depth - 1) ? i + 1 : i];
        end
        default: begin
          slots_d[i] = slots_q[i];
        end
      endcase
    end
  end

  // Slot storage holds payload only.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      slots_q[i] <= slots_d[i];
    end
  end

  // Fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Result from the state after the update.
  assign tail_sum = count_d - CountWidth'(1);
  assign tail_idx = tail_sum[IdxWidth-1:0];

  always_comb begin
    rsp_o.status = status;
    rsp_o.count  = count_d;
    rsp_o.empty  = (count_d == '0);
    if (count_d == '0) begin
      rsp_o.head = '0;
      rsp_o.tail = '0;
    end else begin
      rsp_o.head = slots_d[0];
      rsp_o.tail = slots_d[tail_idx];
    end
  end

endmodule

// ===== hdl/indexed_insert_remove_queue.sv =====
// Queue of 16 words with enqueue, dequeue, insert at a position and remove at a
// position. A request is taken at every clock edge where start is high and busy
// is low; busy stays low, so one request can be taken every cycle. The result
// for a request is shown on the outputs from the clock edge after it is taken,
// marked by done_o for exactly one cycle. Results come in request order. The
// receiver cannot stall, so it must take each result in the cycle it is shown.
// The rate of one request per cycle is set by the slot array, where every slot
// picks its next word in a single pass between the request register and the
// result register.
module indexed_insert_remove_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [iiq_pkg::CmdWidth-1:0]    command_i,
  input  logic [iiq_pkg::PosWidth-1:0]    position_i,
  input  logic [iiq_pkg::DataWidth-1:0]   item_data_i,
  output logic                            done_o,
  output logic [iiq_pkg::StatWidth-1:0]   status_o,
  output logic [iiq_pkg::DataWidth-1:0]   head_word_o,
  output logic [iiq_pkg::DataWidth-1:0]   tail_word_o,
  output logic [iiq_pkg::CountWidth-1:0]  occupancy_o,
  output logic                            is_empty_o
);
  import iiq_pkg::*;

  logic req_valid_q;
  req_t req_q;
  rsp_t rsp;
  logic done_q;
  rsp_t rsp_q;

  // The queue never holds off a request.
  assign busy = 1'b0;

  // Request register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start && !busy;
    end
  end

  // Request register payload.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q.cmd  <= cmd_e'(command_i);
      req_q.pos  <= position_i;
      req_q.data <= item_data_i;
    end
  end

  iiq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_q),
    .req_i       (req_q),
    .rsp_o       (rsp)
  );

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_valid_q;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      rsp_q <= rsp;
    end
  end

  assign done_o      = done_q;
  assign status_o    = rsp_q.status;
  assign head_word_o = rsp_q.head;
  assign tail_word_o = rsp_q.tail;
  assign occupancy_o = rsp_q.count;
  assign is_empty_o  = rsp_q.empty;

endmodule

// ===== hdl/iiq_checker.sv =====
module iiq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic [iiq_pkg::CmdWidth-1:0]    command_i,
  input logic [iiq_pkg::PosWidth-1:0]    position_i,
  input logic [iiq_pkg::DataWidth-1:0]   item_data_i,
  input logic                            done_o,
  input logic [iiq_pkg::StatWidth-1:0]   status_o,
  input logic [iiq_pkg::DataWidth-1:0]   head_word_o,
  input logic [iiq_pkg::DataWidth-1:0]   tail_word_o,
  input logic [iiq_pkg::CountWidth-1:0]  occupancy_o,
  input logic                            is_empty_o
);
  import iiq_pkg::*;

  // Every accepted request gives a result, through the request register and the result register.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("request produced no result");

  // No result appears without a matching accepted request.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without request");

  // Empty flag agrees with the occupancy.
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (is_empty_o == (occupancy_o == '0)))
    else $error("empty flag disagrees with occupancy");

  // The occupancy never exceeds the depth, and an empty queue reports zero words.
  a_empty_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (occupancy_o <= CountWidth'(Depth)) &&
               (!is_empty_o || (head_word_o == '0 && tail_word_o == '0)))
    else $error("bad occupancy or words on empty queue");

endmodule

bind indexed_insert_remove_queue iiq_checker u_iiq_checker (.*);

// ===== bench/tb.sv =====
module tb;
  import iiq_pkg::*;

  localparam int NumRandom = 1000;
  localparam int SegLen    = 64;
  localparam int CycleMax  = 200000;
  localparam int TailWait  = 8;

  // One request as the driver presents it.
  typedef struct {
    cmd_e                 cmd;
    logic [PosWidth-1:0]  pos;
    logic [DataWidth-1:0] data;
    bit                   wait_idle;
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic [CmdWidth-1:0] command_i = '0;
  logic [PosWidth-1:0] position_i = '0;
  logic [DataWidth-1:0] item_data_i = '0;
  logic busy;
  logic done_o;
  logic [StatWidth-1:0] status_o;
  logic [DataWidth-1:0] head_word_o;
  logic [DataWidth-1:0] tail_word_o;
  logic [CountWidth-1:0] occupancy_o;
  logic is_empty_o;

  request_t pending_requests[$];
  request_t presented;
  rsp_t expected_results[$];

  // Shadow copy of the queue contents, head at index zero.
  logic [DataWidth-1:0] shadow_words[Depth];
  int shadow_fill = 0;

  int n_sent = 0;
  int n_seen = 0;
  int n_err = 0;
  int cycles = 0;

  indexed_insert_remove_queue DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .command_i   (command_i),
    .position_i  (position_i),
    .item_data_i (item_data_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .head_word_o (head_word_o),
    .tail_word_o (tail_word_o),
    .occupancy_o (occupancy_o),
    .is_empty_o  (is_empty_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Apply one command to the shadow queue and return the result it causes.
  function automatic rsp_t apply_command(input request_t req);
    rsp_t res;
    res.status = StOk;
    case (req.cmd)
      CmdEnqueue: begin
        if (shadow_fill >= Depth) begin
          res.status = StFull;
        end else begin
          shadow_words[shadow_fill] = req.data;
          shadow_fill++;
        end
      end
      CmdDequeue: begin
        if (shadow_fill == 0) begin
          res.status = StEmpty;
        end else begin
          for (int i = 0; i < shadow_fill - 1; i++) shadow_words[i] = shadow_words[i + 1];
          shadow_fill--;
        end
      end
      CmdInsert: begin
        // A full queue is reported before a bad position.
        if (shadow_fill >= Depth) begin
          res.status = StFull;
        end else if (int'(req.pos) >= shadow_fill) begin
          res.status = StRange;
        end else begin
          for (int i = shadow_fill; i > int'(req.pos); i--) shadow_words[i] = shadow_words[i - 1];
          shadow_words[req.pos] = req.data;
          shadow_fill++;
        end
      end
      default: begin
        // An empty queue is reported before a bad position.
        if (shadow_fill == 0) begin
          res.status = StEmpty;
        end else if (int'(req.pos) >= shadow_fill) begin
          res.status = StRange;
        end else begin
          for (int i = req.pos; i < shadow_fill - 1; i++) shadow_words[i] = shadow_words[i + 1];
          shadow_fill--;
        end
      end
    endcase
    res.head  = (shadow_fill == 0) ? '0 : shadow_words[0];
    res.tail  = (shadow_fill == 0) ? '0 : shadow_words[shadow_fill - 1];
    res.count = CountWidth'(shadow_fill);
    res.empty = (shadow_fill == 0);
    return res;
  endfunction

  // Sender idle share for the current phase of the run.
  function automatic int idle_share(input int sent);
    if (sent < NumRandom / 4) return 0;
    if (sent < NumRandom / 2) return 57;
    if (sent < 3 * NumRandom / 4) return 0;
    return 26;
  endfunction

  task automatic add_request(input cmd_e cmd, input logic [PosWidth-1:0] pos,
                             input logic [DataWidth-1:0] data, input bit wait_idle);
    request_t req;
    req.cmd = cmd;
    req.pos = pos;
    req.data = data;
    req.wait_idle = wait_idle;
    pending_requests.push_back(req);
  endtask

  task automatic check_field(input string name, input logic [DataWidth-1:0] exp_val,
                             input logic [DataWidth-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      n_err++;
    end
  endtask

  // Driver: record the accepted request, then present the next one.
  always @(posedge clk_i) begin
    bit gap;
    bit drained;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(apply_command(presented));
        n_sent <= n_sent + 1;
      end
      if (!start || !busy) begin
        gap = ($urandom_range(99) < idle_share(n_sent));
        drained = !start && (n_sent == n_seen) && !done_o;
        if (pending_requests.size() != 0 && !gap &&
            (!pending_requests[0].wait_idle || drained)) begin
          presented = pending_requests.pop_front();
          start <= 1'b1;
          command_i <= presented.cmd;
          position_i <= presented.pos;
          item_data_i <= presented.data;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t exp_res;
    if (rst_ni && done_o) begin
      n_seen <= n_seen + 1;
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request pending, actual status %0d", $time, status_o);
        n_err++;
      end else begin
        exp_res = expected_results.pop_front();
        check_field("status", DataWidth'(exp_res.status), DataWidth'(status_o));
        check_field("head_word", exp_res.head, head_word_o);
        check_field("tail_word", exp_res.tail, tail_word_o);
        check_field("occupancy", DataWidth'(exp_res.count), DataWidth'(occupancy_o));
        check_field("is_empty", DataWidth'(exp_res.empty), DataWidth'(is_empty_o));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleMax) begin
      $display("indexed_insert_remove_queue verification failed");
      $finish;
    end
  end

  initial begin
    int pick;
    cmd_e cmd;

    // Directed part: empty-queue rejections, range errors, head, middle and tail.
    add_request(CmdDequeue, 4'd0, 32'h0000_0000, 1'b0);
    add_request(CmdRemove, 4'd15, 32'hFFFF_FFFF, 1'b0);
    add_request(CmdInsert, 4'd0, 32'hA5A5_A5A5, 1'b0);
    add_request(CmdEnqueue, 4'd0, 32'h0000_0000, 1'b0);
    add_request(CmdEnqueue, 4'd15, 32'hFFFF_FFFF, 1'b0);
    add_request(CmdInsert, 4'd1, 32'h1234_5678, 1'b0);
    add_request(CmdInsert, 4'd3, 32'h5A5A_5A5A, 1'b0);
    add_request(CmdRemove, 4'd3, 32'h0F0F_0F0F, 1'b0);
    add_request(CmdRemove, 4'd2, 32'hF0F0_F0F0, 1'b0);
    add_request(CmdRemove, 4'd0, 32'h0000_0001, 1'b0);
    add_request(CmdInsert, 4'd0, 32'h8000_0000, 1'b0);
    add_request(CmdDequeue, 4'd7, 32'h7FFF_FFFF, 1'b0);
    add_request(CmdDequeue, 4'd8, 32'hDEAD_BEEF, 1'b0);
    add_request(CmdEnqueue, 4'd0, 32'hC001_D00D, 1'b0);

    // Random part: alternate fill-heavy and drain-heavy stretches so the
    // queue swings between empty and full.
    for (int n = 0; n < NumRandom; n++) begin
      pick = $urandom_range(99);
      if ((n / SegLen) % 2 == 0) begin
        cmd = (pick < 50) ? CmdEnqueue : (pick < 80) ? CmdInsert :
              (pick < 85) ? CmdDequeue : CmdRemove;
      end else begin
        cmd = (pick < 10) ? CmdEnqueue : (pick < 20) ? CmdInsert :
              (pick < 60) ? CmdDequeue : CmdRemove;
      end
      add_request(cmd, PosWidth'($urandom_range(15)), $urandom(), (n % 250) == 0);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pending_requests.size() != 0 || start) @(posedge clk_i);
    while (n_sent != n_seen) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      n_err++;
    end
    if (n_err == 0) begin
      $display("indexed_insert_remove_queue verification clean");
    end else begin
      $display("indexed_insert_remove_queue verification failed");
    end
    $finish;
  end

endmodule
